// File: hdl/fspa_pkg.sv
// ============================================================================
// fspa_pkg
// Shared types and constants for the fixed-slot pool allocator.
// ============================================================================
package fspa_pkg;

    // Pool geometry
    localparam int SLOTS      = 32;
    localparam int SLOT_BYTES = 16;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SIZE_W     = $clog2(SLOT_BYTES + 1);

    // Field widths
    localparam int OPCODE_W    = 2;
    localparam int SLOT_IN_W   = 6;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 5;
    localparam int OFFSET_W    = 9;
    localparam int PROD_W      = SLOT_IN_W + SIZE_W;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    // Request operations
    typedef enum logic [OPCODE_W-1:0] {
        OP_INIT    = 2'd0,
        OP_ACQUIRE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // Free-slot search result
    typedef struct packed {
        logic                  found;
        logic [SLOT_IDX_W-1:0] slot;
    } search_t;

endpackage

// File: hdl/fspa_search.sv
// ============================================================================
// fspa_search
// Rotated priority encoder: first free slot at or after a start index,
// wrapping to the lowest free slot.
// ============================================================================
module fspa_search (
    input  logic [fspa_pkg::SLOTS-1:0]      used_map,
    input  logic [fspa_pkg::SLOT_IDX_W-1:0] start,
    output fspa_pkg::search_t               result
);

    logic [fspa_pkg::SLOTS-1:0]      free_vec;
    logic [fspa_pkg::SLOTS-1:0]      upper_vec;
    logic [fspa_pkg::SLOT_IDX_W-1:0] upper_idx;
    logic [fspa_pkg::SLOT_IDX_W-1:0] low_idx;

    // Free slots at or above the start index
    always_comb begin
        free_vec = ~used_map;
        for (int i = 0; i < fspa_pkg::SLOTS; i++) begin
            upper_vec[i] = free_vec[i] && (fspa_pkg::SLOT_IDX_W'(i) >= start);
        end
    end

    // Lowest set bit of each vector; lower index wins
    always_comb begin
        upper_idx = '0;
        low_idx   = '0;
        for (int i = fspa_pkg::SLOTS - 1; i >= 0; i--) begin
            if (upper_vec[i]) begin
                upper_idx = fspa_pkg::SLOT_IDX_W'(i);
            end
            if (free_vec[i]) begin
                low_idx = fspa_pkg::SLOT_IDX_W'(i);
            end
        end
    end

    assign result.found = |free_vec;
    assign result.slot  = (|upper_vec) ? upper_idx : low_idx;

endmodule

// File: hdl/fixed_slot_pool_allocator_unit.sv
// ============================================================================
// fixed_slot_pool_allocator_unit
// Bitmap allocator for a pool of fixed-size slots with round-robin cursor.
// ============================================================================
// Usage:
//   Requests enter on the s_ stream: opcode (init, acquire, release, look up)
//   and a slot id. Each request yields exactly one result on the m_ stream:
//   status, granted slot, byte offset and a payload clear flag.
//   cfg_we/cfg_wdata set round-robin mode; write it only while idle.
// Pipeline:
//   A request is taken into an input register, resolved by the rotated
//   priority encoder over the used bitmap, and stored in the result
//   register, which drives m_tvalid. One request per cycle is sustained
//   while m_tready stays high; the bitmap and cursor update as the result
//   is loaded, so back-to-back requests see each other's effect.
// Reset:
//   aresetn low empties both registers, frees every slot, zeroes the cursor
//   and selects linear search mode.
// Stall:
//   While m_tready is low the result holds; one more request can wait in the
//   input register, after which s_tready drops.
// ============================================================================
module fixed_slot_pool_allocator_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,     // round_robin_mode
    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fspa_pkg::S_TDATA_W-1:0] s_tdata,       // [1:0] opcode, [7:2] slot_in
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fspa_pkg::M_TDATA_W-1:0] m_tdata        // [1:0] status, [6:2] slot_out,
                                                          // [15:7] byte_offset,
                                                          // [16] clear_request, [23:17] 0
);

    // Registers
    logic                              rr_mode_reg;
    logic                              in_valid_reg;
    fspa_pkg::op_t                     op_reg;
    logic [fspa_pkg::SLOT_IN_W-1:0]    id_reg;
    logic [fspa_pkg::SLOTS-1:0]        used_map_reg, used_map_next;
    logic [fspa_pkg::SLOT_IDX_W-1:0]   cursor_reg, cursor_next;
    logic                              out_valid_reg;
    fspa_pkg::status_t                 status_reg, status_next;
    logic [fspa_pkg::SLOT_OUT_W-1:0]   slot_out_reg, slot_out_next;
    logic [fspa_pkg::OFFSET_W-1:0]     offset_reg, offset_next;
    logic                              clear_reg, clear_next;

    logic                              advance;
    logic                              s_accept;
    logic [fspa_pkg::SLOT_IDX_W-1:0]   start_idx;
    fspa_pkg::search_t                 search;
    logic                              id_in_range;
    logic                              id_used;
    logic [fspa_pkg::SLOT_IDX_W-1:0]   id_idx;
    logic [fspa_pkg::SLOT_IDX_W:0]     grant_inc;
    logic [fspa_pkg::SLOT_IN_W-1:0]    grant_wide;
    logic [fspa_pkg::PROD_W-1:0]       offset_prod;

    // Handshake: the input register moves whenever the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Search start: cursor in round-robin mode, slot zero otherwise
    assign start_idx = (rr_mode_reg &&
                        ({1'b0, cursor_reg} < (fspa_pkg::SLOT_IDX_W + 1)'(fspa_pkg::SLOTS)))
                       ? cursor_reg : '0;

    fspa_search u_search (
        .used_map (used_map_reg),
        .start    (start_idx),
        .result   (search)
    );

    // Id checks and offset
    assign id_in_range = ({1'b0, id_reg} < (fspa_pkg::SLOT_IN_W + 1)'(fspa_pkg::SLOTS));
    assign id_idx      = id_reg[fspa_pkg::SLOT_IDX_W-1:0];
    assign id_used     = id_in_range && used_map_reg[id_idx];
    assign offset_prod = fspa_pkg::PROD_W'(id_reg) *
                         fspa_pkg::PROD_W'(fspa_pkg::SLOT_BYTES);
    assign grant_inc   = {1'b0, search.slot} + 1'b1;
    assign grant_wide  = fspa_pkg::SLOT_IN_W'(search.slot);

    // Request execution
    always_comb begin
        used_map_next = used_map_reg;
        cursor_next   = cursor_reg;
        status_next   = fspa_pkg::ST_OK;
        slot_out_next = '0;
        offset_next   = '0;
        clear_next    = 1'b0;
        case (op_reg)
            fspa_pkg::OP_INIT: begin
                used_map_next = '0;
                cursor_next   = '0;
            end
            fspa_pkg::OP_ACQUIRE: begin
                if (search.found) begin
                    used_map_next[search.slot] = 1'b1;
                    cursor_next   = (grant_inc >= (fspa_pkg::SLOT_IDX_W + 1)'(fspa_pkg::SLOTS))
                                    ? '0 : grant_inc[fspa_pkg::SLOT_IDX_W-1:0];
                    slot_out_next = grant_wide[fspa_pkg::SLOT_OUT_W-1:0];
                end else begin
                    status_next = fspa_pkg::ST_FULL;
                end
            end
            fspa_pkg::OP_RELEASE: begin
                if (id_used) begin
                    used_map_next[id_idx] = 1'b0;
                    clear_next            = 1'b1;
                end else begin
                    status_next = fspa_pkg::ST_INVALID;
                end
            end
            fspa_pkg::OP_LOOKUP: begin
                if (id_used) begin
                    offset_next = offset_prod[fspa_pkg::OFFSET_W-1:0];
                end else begin
                    status_next = fspa_pkg::ST_INVALID;
                end
            end
            default: begin
                status_next = fspa_pkg::ST_INVALID;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rr_mode_reg   <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            used_map_reg  <= '0;
            cursor_reg    <= '0;
        end else begin
            if (cfg_we) begin
                rr_mode_reg <= cfg_wdata;
            end
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                used_map_reg  <= used_map_next;
                cursor_reg    <= cursor_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg <= fspa_pkg::op_t'(s_tdata[1:0]);
            id_reg <= s_tdata[7:2];
        end
        if (advance) begin
            status_reg   <= status_next;
            slot_out_reg <= slot_out_next;
            offset_reg   <= offset_next;
            clear_reg    <= clear_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, clear_reg, offset_reg, slot_out_reg, status_reg};

`ifndef SYNTHESIS
    // Init leaves an empty pool and a zero cursor
    a_init_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (op_reg == fspa_pkg::OP_INIT)
        |=> (used_map_reg == '0) && (cursor_reg == '0))
        else $error("init did not clear pool state");

    // Full is reported only when every slot is used
    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (op_reg == fspa_pkg::OP_ACQUIRE) && !search.found
        |-> (&used_map_reg))
        else $error("acquire reported full with a free slot");

    // A granted slot was free and is used afterward
    a_grant_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (op_reg == fspa_pkg::OP_ACQUIRE) && search.found
        |-> !used_map_reg[search.slot] && used_map_next[search.slot])
        else $error("grant of a used slot or slot not marked");

    // A clear request only comes with an ok status
    a_clear_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && clear_reg |-> (status_reg == fspa_pkg::ST_OK))
        else $error("clear request with failing status");
`endif

endmodule
